/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ASSERT_INV(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// ante implies cons in the same cycle
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// ante implies cons in the next cycle
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_INV(lbl, clk, rst, expr)
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/hrp_pkg.sv */
package hrp_pkg;

   localparam int unsigned LENGTH_LINES = 10;
   localparam int unsigned LINE_W      = 4;
   localparam int unsigned KEY_LEN     = 15;
   localparam int unsigned KEY_POS_W   = $clog2(KEY_LEN + 1);
   localparam int unsigned KEY_HIT_W   = 2 ** KEY_POS_W;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned LEN_W       = 63;
   localparam int unsigned STATUS_W    = 10;
   localparam int unsigned COUNT_W     = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] TERMINATOR = 32'h0D0A_0D0A;

   localparam logic [STATUS_W-1:0] STATUS_NONE = 10'd400;
   localparam logic [STATUS_W-1:0] STATUS_MAX  = 10'd999;
   localparam logic [STATUS_W-1:0] STATUS_OK_LO = 10'd200;
   localparam logic [STATUS_W-1:0] STATUS_OK_HI = 10'd299;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd2048;

   localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
      8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
   };

   typedef enum logic [1:0] {
      OUT_OK         = 2'd0,
      OUT_BAD_STATUS = 2'd1,
      OUT_TOO_LONG   = 2'd2,
      OUT_RX_ERROR   = 2'd3
   } outcome_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      logic [7:0]           data;
      logic                 rx_error;
      logic                 is_digit;
      logic [3:0]           digit;
      logic                 is_space;
      logic                 is_lf;
      logic [KEY_HIT_W-1:0] key_hit;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  header_bytes;
      outcome_type         outcome;
      logic                length_found;
      logic [LEN_W-1:0]    content_length;
      logic [STATUS_W-1:0] status_code;
   } result_type;

endpackage

/* rtl/hrp_front.sv */
module hrp_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              q_full_i,
   output logic              q_push_o,
   output hrp_pkg::item_type q_item_o
);
   import hrp_pkg::*;

   assign req_tready = !q_full_i;
   assign q_push_o   = req_tvalid && !q_full_i;

   // classify the byte so the parser only selects precomputed flags
   always_comb begin
      q_item_o          = '0;
      q_item_o.data     = req_tdata;
      q_item_o.rx_error = req_tuser;
      q_item_o.is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      q_item_o.digit    = q_item_o.is_digit ? 4'(req_tdata - CHAR_ZERO) : 4'd0;
      q_item_o.is_space = (req_tdata == CHAR_SPACE);
      q_item_o.is_lf    = (req_tdata == CHAR_LF);
      for (int i = 0; i < KEY_LEN; i++) begin
         q_item_o.key_hit[i] = (req_tdata == KEY_TEXT[i]);
      end
   end

endmodule

/* rtl/hrp_queue.sv */
`include "assert_macros.svh"

module hrp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  hrp_pkg::item_type item_i,
   output logic              full_o,
   output logic              valid_o,
   input  logic              pop_i,
   output hrp_pkg::item_type item_o
);
   import hrp_pkg::*;

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full_o  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid_o = (count_ff != '0);
   assign item_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_i ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push_i) - QUEUE_CNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= item_i;
      end
   end

   `ASSERT_INV(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `ASSERT_IMP(a_no_pop_empty, clock, reset, pop_i, count_ff != '0)
   `ASSERT_IMP(a_no_push_full, clock, reset, push_i, !full_o)

endmodule

/* rtl/hrp_back.sv */
`include "assert_macros.svh"

module hrp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hrp_pkg::COUNT_W-1:0]  header_limit_i,
   input  logic                         q_valid_i,
   input  hrp_pkg::item_type            q_item_i,
   output logic                         q_pop_o,
   output logic                         rsp_valid_o,
   input  logic                         rsp_ready_i,
   output hrp_pkg::result_type          rsp_o
);
   import hrp_pkg::*;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_MISS,
      PH_SPACE,
      PH_DIGITS,
      PH_DONE
   } line_phase_type;

   typedef enum logic [1:0] {
      ST_TOKEN,
      ST_SPACE,
      ST_DIGITS,
      ST_DONE
   } status_phase_type;

   logic [31:0]            last_four_ff, last_four_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   line_phase_type         line_ph_ff, line_ph_in;
   logic [KEY_POS_W-1:0]   key_pos_ff, key_pos_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   status_phase_type       st_ph_ff, st_ph_in;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic                   seen_ff, seen_in;
   logic                   rsp_valid_ff;
   result_type             rsp_ff, res_in;
   logic                   res_fire;

   logic [STATUS_W+3:0]    status_mul;
   logic [STATUS_W-1:0]    status_sat;
   logic [LEN_W+3:0]       length_mul;
   logic [LEN_W-1:0]       length_sat;

   assign q_pop_o     = q_valid_i && (!rsp_valid_ff || rsp_ready_i);
   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

   // x*10 + d as two shifted adds; saturate on overflow
   always_comb begin
      status_mul = ({4'b0, status_ff} << 3) + ({4'b0, status_ff} << 1)
                 + (STATUS_W + 4)'(q_item_i.digit);
      status_sat = (status_mul > (STATUS_W + 4)'(STATUS_MAX)) ? STATUS_MAX
                 : status_mul[STATUS_W-1:0];
      length_mul = ({4'b0, length_ff} << 3) + ({4'b0, length_ff} << 1)
                 + (LEN_W + 4)'(q_item_i.digit);
      length_sat = (length_mul[LEN_W+3:LEN_W] != 4'b0) ? {LEN_W{1'b1}}
                 : length_mul[LEN_W-1:0];
   end

   always_comb begin
      last_four_in = {last_four_ff[23:0], q_item_i.data};
      count_in     = (count_ff != {COUNT_W{1'b1}}) ? count_ff + 1'b1 : count_ff;
      line_in      = line_ff;
      line_ph_in   = line_ph_ff;
      key_pos_in   = key_pos_ff;
      status_in    = status_ff;
      st_ph_in     = st_ph_ff;
      length_in    = length_ff;
      seen_in      = seen_ff;

      if (line_ff == '0) begin
         unique case (st_ph_ff)
            ST_TOKEN: begin
               if (q_item_i.is_space) st_ph_in = ST_SPACE;
            end
            ST_SPACE: begin
               if (q_item_i.is_digit) begin
                  status_in = STATUS_W'(q_item_i.digit);
                  st_ph_in  = ST_DIGITS;
               end else if (!q_item_i.is_space) begin
                  st_ph_in = ST_DONE;
               end
            end
            ST_DIGITS: begin
               if (q_item_i.is_digit) status_in = status_sat;
               else                   st_ph_in  = ST_DONE;
            end
            ST_DONE: begin
            end
         endcase
      end

      if (q_item_i.is_lf) begin
         if (line_ff != {LINE_W{1'b1}}) line_in = line_ff + 1'b1;
         line_ph_in = PH_KEY;
         key_pos_in = '0;
      end else begin
         unique case (line_ph_ff)
            PH_KEY: begin
               if (line_ff < LINE_W'(LENGTH_LINES) && key_pos_ff < KEY_POS_W'(KEY_LEN) &&
                   q_item_i.key_hit[key_pos_ff]) begin
                  key_pos_in = key_pos_ff + 1'b1;
                  if (key_pos_ff == KEY_POS_W'(KEY_LEN - 1)) begin
                     line_ph_in = PH_SPACE;
                     seen_in    = 1'b1;
                     length_in  = '0;
                  end
               end else begin
                  line_ph_in = PH_MISS;
               end
            end
            PH_SPACE: begin
               if (q_item_i.is_digit) begin
                  length_in  = LEN_W'(q_item_i.digit);
                  line_ph_in = PH_DIGITS;
               end else if (!q_item_i.is_space) begin
                  line_ph_in = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (q_item_i.is_digit) length_in  = length_sat;
               else                   line_ph_in = PH_DONE;
            end
            PH_MISS, PH_DONE: begin
            end
            default: begin
               line_ph_in = PH_MISS;
            end
         endcase
      end

      res_in              = '0;
      res_in.header_bytes = count_in;
      priority if (q_item_i.rx_error) begin
         res_fire            = 1'b1;
         res_in.outcome      = OUT_RX_ERROR;
         res_in.header_bytes = count_ff;
      end else if (count_in >= header_limit_i) begin
         res_fire       = 1'b1;
         res_in.outcome = OUT_TOO_LONG;
      end else if (last_four_in == TERMINATOR) begin
         res_fire              = 1'b1;
         res_in.status_code    = status_in;
         res_in.content_length = length_in;
         res_in.length_found   = seen_in;
         res_in.outcome        = (status_in >= STATUS_OK_LO && status_in <= STATUS_OK_HI)
                               ? OUT_OK : OUT_BAD_STATUS;
      end else begin
         res_fire = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (q_pop_o && res_fire)) begin
         // restart parsing on reset and after every response
         last_four_ff <= '0;
         count_ff     <= '0;
         line_ff      <= '0;
         line_ph_ff   <= PH_KEY;
         key_pos_ff   <= '0;
         status_ff    <= STATUS_NONE;
         st_ph_ff     <= ST_TOKEN;
         length_ff    <= '0;
         seen_ff      <= 1'b0;
      end else if (q_pop_o) begin
         last_four_ff <= last_four_in;
         count_ff     <= count_in;
         line_ff      <= line_in;
         line_ph_ff   <= line_ph_in;
         key_pos_ff   <= key_pos_in;
         status_ff    <= status_in;
         st_ph_ff     <= st_ph_in;
         length_ff    <= length_in;
         seen_ff      <= seen_in;
      end

      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop_o && res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready_i) begin
         rsp_valid_ff <= 1'b0;
      end

      if (q_pop_o && res_fire) begin
         rsp_ff <= res_in;
      end
   end

   `ASSERT_INV(a_status_range, clock, reset, status_ff <= STATUS_MAX)
   `ASSERT_INV(a_key_pos_range, clock, reset, key_pos_ff <= KEY_POS_W'(KEY_LEN))
   `ASSERT_IMP(a_length_needs_key, clock, reset, !seen_ff, length_ff == '0)

endmodule

/* rtl/http_response_header_parser_top.sv */
// HTTP response header parser. Feed the received response one byte per request on req_*
// (req_tuser high flags a receive failure; its byte is ignored). When CR LF CR LF ends the
// header, when the byte count reaches header_limit (csr_wr_data, reset 2048), or on a
// receive failure, one response comes out on rsp_* and the parser restarts. The block
// takes one byte every clock while the queue has room: a classifier and a four-entry
// queue in front, and a parser that consumes one queue entry per cycle unless a response
// waits on rsp_tready, so the rate is set by that single parser step. The output register
// lets the next bytes keep flowing into the queue while a response waits for rsp_tready.
module http_response_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] rx_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [9:0] status_code, [72:10] content_length,
                                    // [88:73] header_bytes, [95:89] zero
   output logic [2:0]  rsp_tuser,   // [0] length_found, [2:1] outcome
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import hrp_pkg::*;

   logic [COUNT_W-1:0] header_limit_ff;
   logic               q_full;
   logic               q_push;
   item_type           q_in_item;
   logic               q_valid;
   logic               q_pop;
   item_type           q_out_item;
   result_type         result;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         header_limit_ff <= csr_wr_data;
      end
   end

   hrp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full_i   (q_full),
      .q_push_o   (q_push),
      .q_item_o   (q_in_item)
   );

   hrp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .item_i  (q_in_item),
      .full_o  (q_full),
      .valid_o (q_valid),
      .pop_i   (q_pop),
      .item_o  (q_out_item)
   );

   hrp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .header_limit_i (header_limit_ff),
      .q_valid_i      (q_valid),
      .q_item_i       (q_out_item),
      .q_pop_o        (q_pop),
      .rsp_valid_o    (rsp_tvalid),
      .rsp_ready_i    (rsp_tready),
      .rsp_o          (result)
   );

   assign rsp_tdata = {7'b0, result.header_bytes, result.content_length, result.status_code};
   assign rsp_tuser = {result.outcome, result.length_found};

endmodule

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hrp_pkg::*;

   localparam logic [7:0]  CHAR_CR      = 8'h0D;
   localparam logic [63:0] LENGTH_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          LINE_CAP     = 15;

   typedef enum logic [1:0] {
      ST_TOKEN,
      ST_SPACES,
      ST_DIGITS,
      ST_DONE
   } status_phase_type;

   typedef enum logic [2:0] {
      LN_KEY,
      LN_MISS,
      LN_SPACE,
      LN_DIGITS,
      LN_DONE
   } line_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       rx_error;
   } rx_byte_type;

   typedef struct {
      logic [STATUS_W-1:0] status_code;
      logic [LEN_W-1:0]    content_length;
      logic                length_found;
      outcome_type         outcome;
      logic [COUNT_W-1:0]  header_bytes;
   } header_summary_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = 16'd0;

   rx_byte_type        rx_bytes[$];
   header_summary_type expected_headers[$];
   logic               req_taken = 1'b0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_left = 0;
   int                 mismatches = 0;

   // parser state mirrored in the testbench
   logic [COUNT_W-1:0]  limit_now = LIMIT_RESET;
   logic [31:0]         prev_four;
   logic [COUNT_W-1:0]  seen_bytes;
   int                  line_idx;
   line_phase_type      line_ph;
   int                  key_idx;
   status_phase_type    status_ph;
   int                  status_acc;
   logic [63:0]         length_acc;
   logic                length_hit;

   http_response_header_parser_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic restart_parse();
      prev_four  = 32'd0;
      seen_bytes = '0;
      line_idx   = 0;
      line_ph    = LN_KEY;
      key_idx    = 0;
      status_ph  = ST_TOKEN;
      status_acc = STATUS_NONE;
      length_acc = 64'd0;
      length_hit = 1'b0;
   endtask

   task automatic emit_summary(input outcome_type oc, input logic keep_fields);
      header_summary_type s;
      s.status_code    = keep_fields ? status_acc[STATUS_W-1:0] : '0;
      s.content_length = keep_fields ? length_acc[LEN_W-1:0] : '0;
      s.length_found   = keep_fields ? length_hit : 1'b0;
      s.outcome        = oc;
      s.header_bytes   = seen_bytes;
      expected_headers.push_back(s);
      restart_parse();
   endtask

   task automatic parse_header_byte(input logic [7:0] b);
      logic        digit;
      logic [63:0] d;
      digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      d = digit ? 64'(b - CHAR_ZERO) : 64'd0;

      if (line_idx == 0) begin
         case (status_ph)
            ST_TOKEN: begin
               if (b == CHAR_SPACE) status_ph = ST_SPACES;
            end
            ST_SPACES: begin
               if (digit) begin
                  status_acc = int'(d);
                  status_ph = ST_DIGITS;
               end else if (b != CHAR_SPACE) begin
                  status_ph = ST_DONE;
               end
            end
            ST_DIGITS: begin
               if (digit) begin
                  status_acc = status_acc * 10 + int'(d);
                  if (status_acc > int'(STATUS_MAX)) status_acc = STATUS_MAX;
               end else begin
                  status_ph = ST_DONE;
               end
            end
            default: ;
         endcase
      end

      if (b == CHAR_LF) begin
         if (line_idx < LINE_CAP) line_idx++;
         line_ph = LN_KEY;
         key_idx = 0;
      end else begin
         case (line_ph)
            LN_KEY: begin
               if (line_idx < LENGTH_LINES && key_idx < KEY_LEN &&
                   b == KEY_TEXT[key_idx]) begin
                  key_idx++;
                  if (key_idx == KEY_LEN) begin
                     line_ph = LN_SPACE;
                     length_hit = 1'b1;
                     length_acc = 64'd0;
                  end
               end else begin
                  line_ph = LN_MISS;
               end
            end
            LN_SPACE: begin
               if (digit) begin
                  length_acc = d;
                  line_ph = LN_DIGITS;
               end else if (b != CHAR_SPACE) begin
                  line_ph = LN_DONE;
               end
            end
            LN_DIGITS: begin
               if (!digit) line_ph = LN_DONE;
               else if (length_acc > (LENGTH_CAP - d) / 10) length_acc = LENGTH_CAP;
               else length_acc = length_acc * 10 + d;
            end
            default: ;
         endcase
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic rx_err);
      if (rx_err) begin
         emit_summary(OUT_RX_ERROR, 1'b0);
      end else begin
         prev_four = {prev_four[23:0], b};
         if (seen_bytes != 16'hFFFF) seen_bytes++;
         parse_header_byte(b);
         if (seen_bytes >= limit_now) begin
            emit_summary(OUT_TOO_LONG, 1'b0);
         end else if (prev_four == TERMINATOR) begin
            emit_summary((status_acc >= int'(STATUS_OK_LO) && status_acc <= int'(STATUS_OK_HI))
                         ? OUT_OK : OUT_BAD_STATUS, 1'b1);
         end
      end
   endtask

   task automatic check_summary();
      header_summary_type  want;
      logic [STATUS_W-1:0] got_status;
      logic [LEN_W-1:0]    got_length;
      logic [COUNT_W-1:0]  got_bytes;
      logic                got_found;
      logic [1:0]          got_outcome;
      got_status  = rsp_tdata[9:0];
      got_length  = rsp_tdata[72:10];
      got_bytes   = rsp_tdata[88:73];
      got_found   = rsp_tuser[0];
      got_outcome = rsp_tuser[2:1];
      if (expected_headers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected status=%0d length=%0d found=%0b outcome=%0d bytes=%0d",
                     $realtime, got_status, got_length, got_found, got_outcome, got_bytes);
      end else begin
         want = expected_headers.pop_front();
         if (got_status != want.status_code || got_length != want.content_length ||
             got_found != want.length_found || got_outcome != want.outcome ||
             got_bytes != want.header_bytes) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response mismatch", $realtime);
               $display("   expected status=%0d length=%0d found=%0b outcome=%0d bytes=%0d",
                        want.status_code, want.content_length, want.length_found,
                        want.outcome, want.header_bytes);
               $display("   actual   status=%0d length=%0d found=%0b outcome=%0d bytes=%0d",
                        got_status, got_length, got_found, got_outcome, got_bytes);
            end
         end
      end
   endtask

   // check responses before predicting: a response never follows its request in the same cycle
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) check_summary();
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tuser);
      end
   end

   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= rx_bytes[0].data;
            req_tuser  <= rx_bytes[0].rx_error;
            void'(rx_bytes.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic rx_err);
      rx_byte_type r;
      r.data = b;
      r.rx_error = rx_err;
      rx_bytes.push_back(r);
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) push_byte(s[i], 1'b0);
   endtask

   task automatic push_crlf();
      push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
   endtask

   function automatic string digit_string(input int n);
      string s;
      s = "";
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
      return s;
   endfunction

   function automatic string status_text();
      case ($urandom_range(7))
         0: return "200";
         1: return "299";
         2: return "199";
         3: return "300";
         4: return "404";
         5: return digit_string($urandom_range(4, 6));
         default: return $sformatf("%0d", $urandom_range(999));
      endcase
   endfunction

   task automatic push_field_line();
      int nd;
      case ($urandom_range(7))
         0, 1, 2: begin
            push_text("Content-Length:");
            repeat ($urandom_range(2)) push_byte(CHAR_SPACE, 1'b0);
            nd = ($urandom_range(3) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 5);
            push_text(digit_string(nd));
            if ($urandom_range(3) == 0) push_text(";x");
         end
         3: begin
            // tab or sign right after the colon ends the value
            push_text("Content-Length:");
            push_text($urandom_range(1) ? "\t" : "+");
            push_text(digit_string(2));
         end
         4: begin
            push_text("Content-Lengt");
            push_byte(8'($urandom_range(255)), 1'b0);
            push_text(": 9");
         end
         5: push_text("Server: x");
         6: push_text("content-length: 12");
         default: repeat ($urandom_range(6)) push_byte(8'($urandom_range(255)), 1'b0);
      endcase
      push_crlf();
   endtask

   task automatic push_header();
      int n_lines;
      case ($urandom_range(5))
         0, 1: begin
            push_text({"HTTP/1.1 ", status_text(), " OK"});
            push_crlf();
         end
         2: begin
            push_text({" ", status_text()});
            push_crlf();
         end
         3: begin
            push_text({"HTTP/1.1  ", status_text(), "x"});
            push_byte(CHAR_LF, 1'b0);
         end
         4: begin
            push_text("HTTP/1.1 X");
            push_crlf();
         end
         default: begin
            push_text({"HTTP/1.1\t", status_text(), " OK"});
            push_crlf();
         end
      endcase
      n_lines = ($urandom_range(9) == 0) ? $urandom_range(9, 17) : $urandom_range(3);
      repeat (n_lines) push_field_line();
      push_crlf();
   endtask

   task automatic push_message();
      int keep;
      case ($urandom_range(9))
         0: push_byte(8'($urandom_range(255)), 1'b1);
         1: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)), 1'b0);
         2: begin
            // cut a header short and end it with a receive failure
            keep = rx_bytes.size();
            push_header();
            keep = $urandom_range(keep, rx_bytes.size() - 1);
            while (rx_bytes.size() > keep) void'(rx_bytes.pop_back());
            push_byte(8'($urandom_range(255)), 1'b1);
         end
         default: push_header();
      endcase
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (rx_bytes.size() != 0 || req_tvalid || expected_headers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] limit, input int send_pct, input int stall_pct,
                            input int n_bytes, input int hold);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_now = limit;
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      hold_left      = hold;
      while (rx_bytes.size() < n_bytes) push_message();
      wait_idle();
   endtask

   initial begin
      restart_parse();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: error on an empty header, bare terminator, edge of the ok range,
      // zero and all-ones bytes, saturating status
      @(posedge clock);
      push_byte(8'hA5, 1'b1);
      push_crlf();
      push_crlf();
      push_text(" 299");
      push_crlf();
      push_crlf();
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h5A, 1'b1);
      push_text(" 2000");
      push_crlf();
      push_crlf();
      wait_idle();

      run_phase(16'hFFFF, 0, 0, 200, 0);
      run_phase(16'd4, 64, 0, 40, 0);
      run_phase(16'd1, 0, 64, 10, 0);
      run_phase(16'd300, 0, 64, 200, 0);
      // long receiver hold-off so the input side backs up
      run_phase(16'd37, 16, 16, 150, 400);
      run_phase(LIMIT_RESET, 0, 0, 200, 0);

      if (mismatches == 0 && expected_headers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hrp_pkg.sv
rtl/hrp_front.sv
rtl/hrp_queue.sv
rtl/hrp_back.sv
rtl/http_response_header_parser_top.sv
tb/sv/testbench.sv
